@@ rtl/mmb_pkg.sv @@
// Package with the shared types, address constants and reset load table of the memory bus.
package mmb_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STORE_DEPTH = 65536;

    localparam logic [ADDR_W-1:0] ADDR_DIVIDER  = 16'hFF04;
    localparam logic [ADDR_W-1:0] ADDR_JOYPAD   = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_SOUND_LO = 16'hFF10;
    localparam logic [ADDR_W-1:0] ADDR_SOUND_HI = 16'hFF3F;

    localparam logic [3:0] INIT_LAST = 4'd8;

    typedef enum logic [2:0] {
        OP_READ8    = 3'd0,
        OP_WRITE8   = 3'd1,
        OP_READ16   = 3'd2,
        OP_WRITE16  = 3'd3,
        OP_GETBIT   = 3'd4,
        OP_SETBIT   = 3'd5,
        OP_CLEARBIT = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [ADDR_W-1:0] init_addr(input logic [3:0] idx);
        logic [ADDR_W-1:0] a;
        unique case (idx)
            4'd0:    a = 16'hFF40;
            4'd1:    a = 16'hFF46;
            4'd2:    a = 16'hFF47;
            4'd3:    a = 16'hFF48;
            4'd4:    a = 16'hFF49;
            4'd5:    a = 16'hFF0F;
            4'd6:    a = 16'hFF02;
            4'd7:    a = ADDR_DIVIDER;
            4'd8:    a = ADDR_JOYPAD;
            default: a = ADDR_JOYPAD;
        endcase
        return a;
    endfunction

    function automatic logic [BYTE_W-1:0] init_data(input logic [3:0] idx);
        logic [BYTE_W-1:0] d;
        unique case (idx)
            4'd0:    d = 8'h91;
            4'd1:    d = 8'hFF;
            4'd2:    d = 8'hFC;
            4'd3:    d = 8'hFF;
            4'd4:    d = 8'hFF;
            4'd5:    d = 8'hE1;
            4'd6:    d = 8'h7E;
            4'd7:    d = 8'hAC;
            4'd8:    d = 8'hFF;
            default: d = 8'hFF;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/mmb_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module mmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mmb_seq.sv @@
// Access sequencer: reset load, read-modify-write of the byte store and result registers.
module mmb_seq
    import mmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [15:0]       i_data_in,
    input  logic [2:0]        i_bit_index,
    output t_ram_req          o_ram_req,
    input  logic [BYTE_W-1:0] i_ram_q,
    output logic              o_result_valid,
    output logic [15:0]       o_read_data,
    output logic              o_timer_reset
);

    t_state            r_state, n_state;
    logic [3:0]        r_init_idx, n_init_idx;
    t_opcode           r_op, n_op;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [15:0]       r_data, n_data;
    logic [2:0]        r_bit, n_bit;
    logic [BYTE_W-1:0] r_lo, n_lo;
    logic              r_valid, n_valid;
    logic [15:0]       r_rd, n_rd;
    logic              r_pulse, n_pulse;
    logic [ADDR_W-1:0] addr_next;
    logic              wr8_pass;
    t_ram_req          req;

    assign addr_next = r_addr + 16'd1;
    assign wr8_pass  = (r_addr != ADDR_DIVIDER) && (r_addr != ADDR_JOYPAD)
                       && !((r_addr >= ADDR_SOUND_LO) && (r_addr <= ADDR_SOUND_HI));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_init_idx <= 4'd0;
            r_valid    <= 1'b0;
            r_pulse    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_idx <= n_init_idx;
            r_valid    <= n_valid;
            r_pulse    <= n_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_addr <= n_addr;
        r_data <= n_data;
        r_bit  <= n_bit;
        r_lo   <= n_lo;
        r_rd   <= n_rd;
    end

    always_comb begin
        n_state    = r_state;
        n_init_idx = r_init_idx;
        n_op       = r_op;
        n_addr     = r_addr;
        n_data     = r_data;
        n_bit      = r_bit;
        n_lo       = r_lo;
        n_valid    = 1'b0;
        n_rd       = r_rd;
        n_pulse    = 1'b0;
        req.we     = 1'b0;
        req.waddr  = r_addr;
        req.wdata  = '0;
        req.raddr  = r_addr;
        unique case (r_state)
            ST_INIT: begin
                req.we    = 1'b1;
                req.waddr = init_addr(r_init_idx);
                req.wdata = init_data(r_init_idx);
                if (r_init_idx == INIT_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_init_idx = r_init_idx + 4'd1;
                end
            end
            ST_IDLE: begin
                req.raddr = i_address;
                if (start) begin
                    n_op    = t_opcode'(i_opcode);
                    n_addr  = i_address;
                    n_data  = i_data_in;
                    n_bit   = i_bit_index;
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_rd    = 16'h0000;
                unique case (r_op)
                    OP_READ8: begin
                        n_rd = {8'h00, i_ram_q};
                    end
                    OP_WRITE8: begin
                        req.we    = wr8_pass;
                        req.wdata = r_data[7:0];
                        n_pulse   = (r_addr == ADDR_DIVIDER);
                    end
                    OP_READ16: begin
                        n_valid   = 1'b0;
                        n_lo      = i_ram_q;
                        req.raddr = addr_next;
                        n_state   = ST_SECOND;
                    end
                    OP_WRITE16: begin
                        n_valid   = 1'b0;
                        req.we    = 1'b1;
                        req.wdata = (r_addr == ADDR_DIVIDER) ? 8'h00 : r_data[7:0];
                        n_state   = ST_SECOND;
                    end
                    OP_GETBIT: begin
                        n_rd = {15'd0, i_ram_q[r_bit]};
                    end
                    OP_SETBIT: begin
                        req.we    = 1'b1;
                        req.wdata = i_ram_q | (8'd1 << r_bit);
                    end
                    OP_CLEARBIT: begin
                        req.we    = 1'b1;
                        req.wdata = i_ram_q & ~(8'd1 << r_bit);
                    end
                    default: begin
                        n_rd = 16'h0000;
                    end
                endcase
            end
            ST_SECOND: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_rd    = 16'h0000;
                if (r_op == OP_READ16) begin
                    n_rd = {i_ram_q, r_lo};
                end else begin
                    req.we    = 1'b1;
                    req.waddr = addr_next;
                    req.wdata = (addr_next == ADDR_DIVIDER) ? 8'h00 : r_data[15:8];
                    n_pulse   = (r_addr == ADDR_DIVIDER) || (addr_next == ADDR_DIVIDER);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ram_req      = req;
    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_read_data    = r_rd;
    assign o_timer_reset  = r_pulse;

endmodule

@@ rtl/mapped_memory_bus_with_io_filter_top.sv @@
// Top level of the 64 KiB byte-addressed memory bus with its I/O write filter.
// An access is taken when start is high and busy is low. Busy then stays high in state
// ST_FIRST for byte accesses and bit operations and in ST_FIRST and ST_SECOND for 16-bit
// accesses, because the single read and single write port of the byte store is touched
// once per byte, and the result strobe o_result_valid follows in the cycle after that. Each
// result is shown for exactly one cycle and the receiver cannot stall it. After reset the
// block is busy while it loads the nine preset I/O bytes.
module mapped_memory_bus_with_io_filter_top
    import mmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [15:0] i_data_in,
    input  logic [2:0]  i_bit_index,
    output logic        o_result_valid,
    output logic [15:0] o_read_data,
    output logic        o_timer_reset
);

    t_ram_req          ram_req;
    logic [BYTE_W-1:0] ram_q;

    mmb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_data_in      (i_data_in),
        .i_bit_index    (i_bit_index),
        .o_ram_req      (ram_req),
        .i_ram_q        (ram_q),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data),
        .o_timer_reset  (o_timer_reset)
    );

    mmb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transfer did not raise busy.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("Result strobe without a preceding access.");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("Result strobe held for more than one cycle.");

    a_pulse_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_timer_reset |-> o_result_valid)
        else $error("Timer reset pulse outside a result transfer.");

endmodule
